// File: hw/rtl/quintic_segment_coefficients_macros.svh
// Assertion macros for the quintic segment coefficient block.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef QUINTIC_SEGMENT_COEFFICIENTS_MACROS_SVH
`define QUINTIC_SEGMENT_COEFFICIENTS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/qsc_pkg.sv
// Shared types and constants of the quintic segment coefficient block.
// Depends on nothing; used by every module of the block.
package qsc_pkg;

    localparam int IN_W          = 32;
    localparam int DUR_W         = 24;
    localparam int OUT_W         = 48;
    localparam int TERM_W        = 40;
    localparam int NCOEF_DIV     = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int S_DATA_W      = 6 * IN_W + DUR_W;
    localparam int M_DATA_W      = 6 * OUT_W;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // One classified segment: numerator terms for the cubic, quartic and
    // quintic coefficients, plus the directly known coefficients.
    typedef struct packed {
        logic [NCOEF_DIV-1:0][TERM_W-1:0] t0;
        logic [NCOEF_DIV-1:0][TERM_W-1:0] t1;
        logic [NCOEF_DIV-1:0][TERM_W-1:0] t2;
        logic [IN_W-1:0]                  c0;
        logic [IN_W-1:0]                  c1;
        logic [IN_W-1:0]                  c2;
        logic [DUR_W-1:0]                 dur;
        logic                             zero_dur;
    } job_t;

endpackage

// File: hw/rtl/qsc_front.sv
// Front end: takes an input word, forms the numerator terms and flags a
// zero duration. Depends on qsc_pkg.
module qsc_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [qsc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         q_wr_valid,
    input  logic                         q_wr_ready,
    output qsc_pkg::job_t                q_wr_data
);
    import qsc_pkg::*;

    localparam logic signed [TERM_W-1:0] K2  = TERM_W'(2);
    localparam logic signed [TERM_W-1:0] K3  = TERM_W'(3);
    localparam logic signed [TERM_W-1:0] K6  = TERM_W'(6);
    localparam logic signed [TERM_W-1:0] K8  = TERM_W'(8);
    localparam logic signed [TERM_W-1:0] K12 = TERM_W'(12);
    localparam logic signed [TERM_W-1:0] K14 = TERM_W'(14);
    localparam logic signed [TERM_W-1:0] K16 = TERM_W'(16);
    localparam logic signed [TERM_W-1:0] K20 = TERM_W'(20);
    localparam logic signed [TERM_W-1:0] K30 = TERM_W'(30);

    logic signed [TERM_W-1:0] p0, v0, a0, p1, v1, a1, h;
    logic signed [TERM_W-1:0] a_mag, half, c2_w;
    logic [DUR_W-1:0]         dur;

    assign p0  = TERM_W'($signed(s_tdata[0*IN_W +: IN_W]));
    assign v0  = TERM_W'($signed(s_tdata[1*IN_W +: IN_W]));
    assign a0  = TERM_W'($signed(s_tdata[2*IN_W +: IN_W]));
    assign p1  = TERM_W'($signed(s_tdata[3*IN_W +: IN_W]));
    assign v1  = TERM_W'($signed(s_tdata[4*IN_W +: IN_W]));
    assign a1  = TERM_W'($signed(s_tdata[5*IN_W +: IN_W]));
    assign dur = s_tdata[6*IN_W +: DUR_W];
    assign h   = p1 - p0;

    // Half the start acceleration, rounded to nearest with ties away from zero.
    assign a_mag = a0[TERM_W-1] ? -a0 : a0;
    assign half  = (a_mag + TERM_W'(1)) >>> 1;
    assign c2_w  = a0[TERM_W-1] ? -half : half;

    always_comb begin
        q_wr_data.t0[0] = K20 * h;
        q_wr_data.t1[0] = -(K8 * v1 + K12 * v0);
        q_wr_data.t2[0] = a1 - K3 * a0;
        q_wr_data.t0[1] = -(K30 * h);
        q_wr_data.t1[1] = K14 * v1 + K16 * v0;
        q_wr_data.t2[1] = K3 * a0 - K2 * a1;
        q_wr_data.t0[2] = K12 * h;
        q_wr_data.t1[2] = -(K6 * (v1 + v0));
        q_wr_data.t2[2] = a1 - a0;
        q_wr_data.c0       = s_tdata[0*IN_W +: IN_W];
        q_wr_data.c1       = s_tdata[1*IN_W +: IN_W];
        q_wr_data.c2       = c2_w[IN_W-1:0];
        q_wr_data.dur      = dur;
        q_wr_data.zero_dur = (dur == '0);
    end

    assign q_wr_valid = s_tvalid;
    assign s_tready   = q_wr_ready;

endmodule

// File: hw/rtl/qsc_fifo.sv
// Short job queue between the front end and the solver.
// Depends on qsc_pkg for the job type.
module qsc_fifo #(
    parameter int DEPTH = qsc_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  qsc_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output qsc_pkg::job_t rd_data
);
    import qsc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/qsc_back.sv
// Solver: powers of T, numerators by Horner's rule and rounded quotients,
// using one shift-add multiplier and one restoring divider. Depends on qsc_pkg.
module qsc_back #(
    parameter int FRAC_BITS = qsc_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_rd_valid,
    output logic                          q_rd_ready,
    input  qsc_pkg::job_t                 q_rd_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [5:0][qsc_pkg::OUT_W-1:0] m_coef,
    output qsc_pkg::status_t              m_status
);
    import qsc_pkg::*;

    localparam int MAXS  = (FRAC_BITS > DUR_W) ? FRAC_BITS : DUR_W;
    localparam int NW    = TERM_W + 2 * MAXS + 2;
    localparam int MW    = NW + 3 * FRAC_BITS + 2;
    localparam int QW    = OUT_W + 1;
    localparam int DW    = 5 * DUR_W + 2 + QW;
    localparam int W     = (MW > DW) ? MW : DW;
    localparam int CNT_W = $clog2(QW);
    localparam int MIW   = $clog2(DUR_W);

    localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_POST, S_DIV, S_FIN, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_D2, PH_D3, PH_NA, PH_NB, PH_DK
    } phase_t;

    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    job_t                     job_reg, job_next;
    logic [1:0]               kidx_reg, kidx_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [W-1:0]      acc_reg, acc_next;
    logic signed [W-1:0]      x_reg, x_next;
    logic [W-1:0]             dk_reg, dk_next;
    logic [W-1:0]             rem_reg, rem_next;
    logic [W-1:0]             dsh_reg, dsh_next;
    logic [QW-1:0]            q_reg, q_next;
    logic                     neg_reg, neg_next;
    logic                     sat_reg, sat_next;
    logic [5:0][OUT_W-1:0]    coef_reg, coef_next;
    status_t                  status_reg, status_next;
    logic                     ovalid_reg, ovalid_next;

    logic signed [W-1:0]      num;
    logic [W-1:0]             mag, mag_sh;
    logic                     ge, over;
    logic [OUT_W-1:0]         qv, coef_val;

    assign num = acc_reg + (W'($signed(job_reg.t0[kidx_reg])) <<< (2 * FRAC_BITS));
    assign mag = num[W-1] ? W'(-num) : W'(num);
    assign ge  = (rem_reg >= dsh_reg);
    assign qv  = q_reg[OUT_W-1:0];

    always_comb begin
        case (kidx_reg)
            2'd0:    mag_sh = mag << (FRAC_BITS + 1);
            2'd1:    mag_sh = mag << (2 * FRAC_BITS + 1);
            default: mag_sh = mag << (3 * FRAC_BITS + 1);
        endcase
    end

    // Saturate the rounded quotient magnitude with its sign applied.
    always_comb begin
        if (!neg_reg) begin
            over     = q_reg[QW-1] || qv[OUT_W-1];
            coef_val = over ? POS_LIM : qv;
        end else begin
            over     = q_reg[QW-1] || (qv[OUT_W-1] && (qv[OUT_W-2:0] != '0));
            coef_val = over ? NEG_LIM : -qv;
        end
    end

    assign q_rd_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        job_next    = job_reg;
        kidx_next   = kidx_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        x_next      = x_reg;
        dk_next     = dk_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        q_next      = q_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        coef_next   = coef_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (q_rd_valid) begin
                    job_next     = q_rd_data;
                    kidx_next    = '0;
                    sat_next     = 1'b0;
                    coef_next[0] = OUT_W'($signed(q_rd_data.c0));
                    coef_next[1] = OUT_W'($signed(q_rd_data.c1));
                    coef_next[2] = OUT_W'($signed(q_rd_data.c2));
                    if (q_rd_data.zero_dur) begin
                        coef_next[3] = '0;
                        coef_next[4] = '0;
                        coef_next[5] = '0;
                        state_next   = S_OUT;
                    end else begin
                        x_next     = W'($signed({1'b0, q_rd_data.dur}));
                        acc_next   = '0;
                        cnt_next   = CNT_W'(DUR_W - 1);
                        phase_next = PH_D2;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                acc_next = (acc_reg <<< 1) +
                           (job_reg.dur[cnt_reg[MIW-1:0]] ? x_reg : W'(0));
                if (cnt_reg == '0) begin
                    state_next = S_POST;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_POST: begin
                cnt_next   = CNT_W'(DUR_W - 1);
                acc_next   = '0;
                state_next = S_MUL;
                case (phase_reg)
                    PH_D2: begin
                        dk_next    = acc_reg;
                        x_next     = acc_reg;
                        phase_next = PH_D3;
                    end
                    PH_D3, PH_DK: begin
                        dk_next    = acc_reg;
                        x_next     = W'($signed(job_reg.t2[kidx_reg]));
                        phase_next = PH_NA;
                    end
                    PH_NA: begin
                        x_next     = acc_reg +
                                     (W'($signed(job_reg.t1[kidx_reg])) <<< FRAC_BITS);
                        phase_next = PH_NB;
                    end
                    default: begin
                        // Numerator is complete: set up the rounded division.
                        neg_next   = num[W-1];
                        rem_next   = mag_sh + (dk_reg << 1);
                        dsh_next   = dk_reg << (2 + QW - 1);
                        q_next     = '0;
                        cnt_next   = CNT_W'(QW - 1);
                        state_next = S_DIV;
                    end
                endcase
            end
            S_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[QW-2:0], ge};
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_FIN: begin
                coef_next[3 + int'(kidx_reg)] = coef_val;
                sat_next = sat_reg || over;
                if (kidx_reg == 2'd2) begin
                    state_next = S_OUT;
                end else begin
                    kidx_next  = kidx_reg + 2'd1;
                    x_next     = dk_reg;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(DUR_W - 1);
                    phase_next = PH_DK;
                    state_next = S_MUL;
                end
            end
            S_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    if (job_reg.zero_dur) begin
                        status_next = ST_ZERO;
                    end else if (sat_reg) begin
                        status_next = ST_SAT;
                    end else begin
                        status_next = ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_D2;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
        job_reg    <= job_next;
        kidx_reg   <= kidx_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        dk_reg     <= dk_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        status_reg <= status_next;
        if (state_reg == S_OUT && (!ovalid_reg || m_tready)) begin
            m_coef <= coef_reg;
        end
        coef_reg <= coef_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_status = status_reg;

endmodule

// File: hw/rtl/quintic_segment_coefficients.sv
// Top level of the quintic segment coefficient block (one axis).
// Depends on qsc_pkg, qsc_front, qsc_fifo, qsc_back and the macros header.
//
//   channel  direction  payload (lowest bits first)
//   s_       in         p0, v0, a0 (start boundary), p1, v1, a1 (end boundary),
//                       segment duration T
//   m_       out        coef_0 .. coef_5 in tdata, status in tuser
//
// A segment with nonzero duration keeps the solver busy while it pops the
// job, forms ten products (the shared shift-add multiplier retires one
// duration bit per cycle, plus a setup step), runs three restoring divisions
// each with a finishing step, and loads the output register. A zero
// duration skips the products and divisions in the solver. The queue
// registers each job between input and solver.
// Reset is synchronous and active low. The solver only stalls while the
// output register still holds an unaccepted word; the two-word queue lets
// the input accept new segments while the solver works.
`include "quintic_segment_coefficients_macros.svh"

module quintic_segment_coefficients #(
    parameter int FRAC_BITS = qsc_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // p0, v0, a0, p1, v1, a1 (32 bits each), duration T (24 bits)
    input  logic [qsc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // coef_0, coef_1, coef_2, coef_3, coef_4, coef_5
    output logic [qsc_pkg::M_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]                   m_tuser
);
    import qsc_pkg::*;

    job_t                  wr_job, rd_job;
    logic                  wr_valid, wr_ready, rd_valid, rd_ready;
    logic [5:0][OUT_W-1:0] coef;
    status_t               status;

    // The front end classifies each input word into a job for the queue.
    qsc_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_wr_valid (wr_valid),
        .q_wr_ready (wr_ready),
        .q_wr_data  (wr_job)
    );

    qsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_job),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_job)
    );

    // The solver pops one job at a time and owns the output register.
    qsc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rd_valid (rd_valid),
        .q_rd_ready (rd_ready),
        .q_rd_data  (rd_job),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_coef     (coef),
        .m_status   (status)
    );

    assign m_tdata = coef;
    assign m_tuser = status;

    // A zero duration leaves the three solved coefficients at zero.
    `QSC_ASSERT_NOW(a_zero_dur_coefs, m_tvalid && (m_tuser == ST_ZERO), m_tdata[M_DATA_W-1:3*OUT_W] == '0, "zero duration with nonzero solved coefficient")
    // The constant and linear terms are sign-extended inputs.
    `QSC_ASSERT_NOW(a_c0_sext, m_tvalid, (m_tdata[OUT_W-1:IN_W-1] == '0) || (m_tdata[OUT_W-1:IN_W-1] == '1), "coef_0 not sign extended")
    `QSC_ASSERT_NOW(a_c1_sext, m_tvalid, (m_tdata[2*OUT_W-1:OUT_W+IN_W-1] == '0) || (m_tdata[2*OUT_W-1:OUT_W+IN_W-1] == '1), "coef_1 not sign extended")

endmodule
